[rtl/magnetometer_iron_calibration_top_macros.svh]
// Assertion macros used by the checker file of the iron calibration block.
// Depends on nothing; include by bare file name.
`ifndef MAGNETOMETER_IRON_CALIBRATION_TOP_MACROS_SVH
`define MAGNETOMETER_IRON_CALIBRATION_TOP_MACROS_SVH
// Implication checked on every clock, quiet in reset.
`define MIC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, quiet in reset.
`define MIC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/mic_pkg.sv]
// Package of the iron calibration block: codes, widths and shared types.
// Depends on nothing.
package mic_pkg;
  localparam int unsigned ScaleFracBits = 16;
  localparam int unsigned NumAxes = 3;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_END    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTREADY = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_STARTED  = 3'd3,
    ST_DONE     = 3'd4,
    ST_FAILED   = 3'd5
  } status_t;

  localparam logic [1:0] REG_ADJUST_X = 2'd0;
  localparam logic [1:0] REG_ADJUST_Y = 2'd1;
  localparam logic [1:0] REG_ADJUST_Z = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_ADJ, S_DIFF, S_MUL, S_ROUND, S_EXT,
    S_SPAN, S_SUM, S_DIV, S_DIVSTORE, S_EMIT
  } fsm_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage

[rtl/mic_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface mic_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/mic_sermul.sv]
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift-add.
// Depends on mic_pkg.
module mic_sermul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  mic_pkg::mul_ctl_t   ctl_in,
  input  logic [AW-1:0]       a,
  input  logic [BW-1:0]       b,
  output logic                busy,
  output logic [AW+BW-1:0]    product
);
  import mic_pkg::*;
  localparam int unsigned CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] mcand;
  logic [BW-1:0]    mplier;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
      count <= CW'(BW);
      acc <= '0;
      mcand <= {{BW{1'b0}}, a};
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end
  assign product = acc;
endmodule

[rtl/mic_serdiv.sv]
// Restoring serial divider: one quotient bit per cycle.
// Depends on mic_pkg.
module mic_serdiv #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  mic_pkg::mul_ctl_t ctl_in,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  output logic              busy,
  output logic [NW-1:0]     quot
);
  import mic_pkg::*;
  localparam int unsigned CW = $clog2(NW + 1);
  logic [DW:0]    rem;
  logic [DW:0]    trial;
  logic [NW-1:0]  nsh;
  logic [DW-1:0]  d;
  logic [CW-1:0]  count;

  assign trial = {rem[DW-1:0], nsh[NW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
      count <= CW'(NW);
      rem <= '0;
      nsh <= num;
      d <= den;
      quot <= '0;
    end else if (busy) begin
      if (!trial[DW]) rem <= trial;
      else rem <= {rem[DW-1:0], nsh[NW-1]};
      quot <= {quot[NW-2:0], ~trial[DW]};
      nsh <= nsh << 1;
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

[rtl/magnetometer_iron_calibration_top.sv]
// Top level of the magnetometer hard/soft iron calibration block.
// Depends on mic_pkg, mic_if, mic_sermul, mic_serdiv.
//
//  channel | direction | payload
//  req     | in        | operation, status_one, raw_x/y/z, status_two
//  res     | out       | status, out_x/y/z, calibrating
//  cfg     | in        | cfg_we, cfg_index, cfg_data (adjust_x/y/z)
//
// Steps: a good sample passes each axis through adjust, difference, the
//   multiplier (one scale bit per cycle) and rounding, then S_EXT updates the extremes.
// An end operation forms the spans and their sum, then runs the divider for
//   35+SCALE_FRAC_BITS quotient bits per axis.
// Begin and status-only requests go from the decide state straight to emit.
// Reset is synchronous; it restores bias 0, scale 1.0 and cleared extremes.
// One request at a time: the next is taken once the result leaves the
//   output register.
module magnetometer_iron_calibration_top #(
  parameter int unsigned SCALE_FRAC_BITS = mic_pkg::ScaleFracBits
) (
  input  logic        clk,
  input  logic        rst,
  mic_if.sink         req,
  mic_if.source       res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mic_pkg::*;
  localparam int unsigned PW = 33 + 32;
  localparam int unsigned NW = 35 + SCALE_FRAC_BITS;
  localparam logic [31:0] ScaleOne = 32'(64'd1 << SCALE_FRAC_BITS);

  fsm_t state, state_next;
  logic [7:0]  adjust [NumAxes];
  logic signed [31:0] bias [NumAxes];
  logic [31:0] scale [NumAxes];
  logic signed [31:0] amin [NumAxes];
  logic signed [31:0] amax [NumAxes];
  logic collecting, seen_sample;

  // request latch
  logic [1:0]  op;
  logic [7:0]  st1, st2;
  logic signed [15:0] rawv [NumAxes];
  logic [1:0]  axis;
  logic signed [31:0] adj;
  logic [32:0] mag;
  logic        neg;
  logic signed [31:0] outv [NumAxes];
  status_t     status_r;
  logic [33:0] span [NumAxes];
  logic [35:0] sum;
  logic        out_valid;
  logic [31:0] qhold [NumAxes];

  mul_ctl_t mctl, dctl;
  logic mbusy, dbusy;
  logic [PW-1:0] prod;
  logic [NW-1:0] quot;

  // magnitude of the biased value; adj and axis hold steady through the multiply
  assign neg = adj < bias[axis];
  assign mag = neg ? 33'(33'(bias[axis]) - 33'(adj)) : 33'(33'(adj) - 33'(bias[axis]));

  mic_sermul #(.AW(33), .BW(32)) u_mul (
    .clk, .rst, .ctl_in(mctl), .a(mag), .b(scale[axis]), .busy(mbusy), .product(prod));

  // the divide started on leaving S_DIVSTORE is for the next axis
  logic [1:0]    den_axis;
  logic [NW-1:0] num;
  logic [35:0]   den;
  assign den_axis = (state == S_DIVSTORE && axis != 2'd2) ? axis + 2'd1 : axis;
  assign sum = 36'(span[0]) + 36'(span[1]) + 36'(span[2]);
  assign den = 36'(span[den_axis]) * 36'd3;
  assign num = (NW'(sum) << SCALE_FRAC_BITS) + NW'(den >> 1);
  mic_serdiv #(.NW(NW), .DW(36)) u_div (
    .clk, .rst, .ctl_in(dctl), .num(num), .den(den), .busy(dbusy), .quot(quot));

  // rounding and saturation of the scaled magnitude
  logic [PW-1:0] rsum;
  logic [PW-1:0] rmag;
  assign rsum = prod + (PW'(1) << (SCALE_FRAC_BITS - 1));
  assign rmag = rsum >> SCALE_FRAC_BITS;

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    mctl = '0;
    dctl = '0;
    unique case (state)
      S_IDLE:     if (req.valid && req.ready) state_next = S_DECIDE;
      S_DECIDE: begin
        if (op == OP_SAMPLE && st1[0] && !st2[3]) state_next = S_ADJ;
        else if (op == OP_END && collecting && seen_sample) state_next = S_SPAN;
        else state_next = S_EMIT;
      end
      S_ADJ:      state_next = S_DIFF;
      S_DIFF: begin
        mctl.start = 1'b1;
        state_next = S_MUL;
      end
      S_MUL:      if (!mbusy) state_next = S_ROUND;
      S_ROUND:    state_next = (axis == 2'd2) ? S_EXT : S_ADJ;
      S_EXT:      state_next = S_EMIT;
      S_SPAN:     state_next = S_SUM;
      S_SUM: begin
        if (span[0][33] || span[1][33] || span[2][33] ||
            span[0] == '0 || span[1] == '0 || span[2] == '0) state_next = S_EMIT;
        else begin
          dctl.start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV:      if (!dbusy) state_next = S_DIVSTORE;
      S_DIVSTORE: begin
        if (axis == 2'd2) state_next = S_EMIT;
        else begin
          dctl.start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_EMIT:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumAxes; i++) begin
        adjust[i] <= 8'd128;
        bias[i] <= '0;
        scale[i] <= ScaleOne;
        amin[i] <= 32'sh7FFFFFFF;
        amax[i] <= 32'sh80000000;
      end
      collecting <= 1'b0;
      seen_sample <= 1'b0;
      out_valid <= 1'b0;
      axis <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ADJUST_X: adjust[0] <= cfg_data;
          REG_ADJUST_Y: adjust[1] <= cfg_data;
          REG_ADJUST_Z: adjust[2] <= cfg_data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          op <= req.payload.operation;
          st1 <= req.payload.status_one;
          st2 <= req.payload.status_two;
          rawv[0] <= req.payload.raw_x;
          rawv[1] <= req.payload.raw_y;
          rawv[2] <= req.payload.raw_z;
          axis <= '0;
        end
        S_DECIDE: begin
          for (int i = 0; i < NumAxes; i++) outv[i] <= '0;
          if (op == OP_BEGIN) begin
            for (int i = 0; i < NumAxes; i++) begin
              amin[i] <= 32'sh7FFFFFFF;
              amax[i] <= 32'sh80000000;
            end
            seen_sample <= 1'b0;
            collecting <= 1'b1;
            status_r <= ST_STARTED;
          end else if (op == OP_END) begin
            status_r <= ST_FAILED;
            collecting <= 1'b0;
            seen_sample <= 1'b0;
          end else if (op == OP_SAMPLE) begin
            if (!st1[0]) status_r <= ST_NOTREADY;
            else if (st2[3]) status_r <= ST_OVERFLOW;
            else status_r <= ST_OK;
          end else status_r <= ST_NOTREADY;
        end
        S_ADJ: adj <= 32'(rawv[axis]) * $signed({1'b0, 9'(adjust[axis]) + 9'd128});
        S_ROUND: begin
          if (neg) begin
            if (rmag >= PW'(64'h80000000)) outv[axis] <= 32'sh80000000;
            else outv[axis] <= -$signed(32'(rmag));
          end else begin
            if (rmag > PW'(64'h7FFFFFFF)) outv[axis] <= 32'sh7FFFFFFF;
            else outv[axis] <= $signed(32'(rmag));
          end
          axis <= axis + 2'd1;
        end
        S_EXT: begin
          if (collecting) begin
            seen_sample <= 1'b1;
            for (int i = 0; i < NumAxes; i++) begin
              if ($signed(32'(rawv[i]) * $signed({23'd0, 9'(adjust[i]) + 9'd128}))
                  < amin[i])
                amin[i] <= 32'(rawv[i]) * $signed({23'd0, 9'(adjust[i]) + 9'd128});
              if ($signed(32'(rawv[i]) * $signed({23'd0, 9'(adjust[i]) + 9'd128}))
                  > amax[i])
                amax[i] <= 32'(rawv[i]) * $signed({23'd0, 9'(adjust[i]) + 9'd128});
            end
          end
        end
        S_SPAN: begin
          for (int i = 0; i < NumAxes; i++)
            span[i] <= 34'(34'(amax[i]) - 34'(amin[i]));
        end
        S_SUM: begin
          axis <= '0;
        end
        S_DIVSTORE: begin
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            status_r <= ST_DONE;
            for (int i = 0; i < NumAxes; i++)
              bias[i] <= 32'((34'(amax[i]) + 34'(amin[i])) / 2);
          end
        end
        S_EMIT: out_valid <= 1'b1;
        default: ;
      endcase
      // hold each quotient per axis; commit all three only on success
      if (state == S_DIV && !dbusy) begin
        qhold[axis] <= (quot > NW'(33'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(quot);
      end
      if (state == S_DIVSTORE && axis == 2'd2) begin
        scale[0] <= qhold[0];
        scale[1] <= qhold[1];
        scale[2] <= (quot > NW'(33'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(quot);
      end
    end
  end

  assign res.payload.status = status_r;
  assign res.payload.out_x = outv[0];
  assign res.payload.out_y = outv[1];
  assign res.payload.out_z = outv[2];
  assign res.payload.calibrating = collecting;
endmodule

[rtl/mic_checker.sv]
// Port-level checker of the iron calibration block, bound to the top level.
// Depends on the macro header.
`include "magnetometer_iron_calibration_top_macros.svh"
module mic_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [31:0] out_x
);
  `MIC_ASSERT_IMP(a_status_range, clk, rst, out_valid, out_status <= 3'd5)
  `MIC_ASSERT_IMP(a_zero_unless_ok, clk, rst, out_valid && out_status != 3'd0, out_x == 32'd0)
  `MIC_ASSERT_IMP(a_one_at_time, clk, rst, out_valid, !in_ready)
  `MIC_ASSERT_NXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
endmodule

bind magnetometer_iron_calibration_top mic_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(req.ready),
  .out_valid(res.valid), .out_ready(res.ready), .out_status(res.payload.status),
  .out_x(res.payload.out_x));

[bench/tb_magnetometer_iron_calibration_top.sv]
// Testbench of the magnetometer iron calibration block: random and directed
// requests, a scoreboard that predicts every result. Depends on mic_pkg, mic_if.
`timescale 1ns / 1ps

module tb_magnetometer_iron_calibration_top;
  import mic_pkg::*;

  typedef struct packed {
    op_t               operation;
    logic [7:0]        status_one;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic [7:0]        status_two;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               calibrating;
  } result_t;

  // Predict corrected samples and calibration results, and hold them until the
  // block hands its results back.
  class iron_scoreboard;
    int unsigned adjust[3];
    int          bias[3];
    int unsigned scale[3];
    int          lo[3];
    int          hi[3];
    bit          collecting;
    bit          seen;
    result_t     awaited[$];
    int          errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        adjust[i] = 128;
        bias[i]   = 0;
        scale[i]  = 32'd1 << ScaleFracBits;
      end
      clear_extremes();
      collecting = 0;
      seen       = 0;
      errors     = 0;
    endfunction

    function void clear_extremes();
      for (int i = 0; i < 3; i++) begin
        lo[i] = 32'sh7fffffff;
        hi[i] = 32'sh80000000;
      end
    endfunction

    function void set_adjust(int idx, logic [7:0] value);
      adjust[idx] = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Subtract bias, scale, round half away from zero, saturate.
    function logic signed [31:0] correct(longint adj, int axis);
      longint diff;
      bit neg;
      longint unsigned m, s, r;
      diff = adj - longint'(bias[axis]);
      neg  = diff < 0;
      m    = neg ? -diff : diff;
      s    = scale[axis];
      if (s != 0 && m > (64'd1 << (32 + ScaleFracBits)) / s)
        r = 64'd1 << 32;
      else
        r = (m * s + (64'd1 << (ScaleFracBits - 1))) >> ScaleFracBits;
      if (neg) begin
        if (r >= (64'd1 << 31)) return 32'sh80000000;
        return 32'(-r);
      end
      if (r > 64'h7fffffff) return 32'sh7fffffff;
      return 32'(r);
    endfunction

    function status_t finish_run();
      longint span[3];
      longint unsigned sum, num, den, q;
      bit ok;
      ok = collecting && seen;
      collecting = 0;
      seen = 0;
      if (!ok) return ST_FAILED;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        span[i] = longint'(hi[i]) - longint'(lo[i]);
        if (span[i] <= 0) return ST_FAILED;
        sum += span[i];
      end
      for (int i = 0; i < 3; i++) begin
        num = sum << ScaleFracBits;
        den = 3 * span[i];
        q = (num + den / 2) / den;
        if (q > 64'hffffffff) q = 64'hffffffff;
        bias[i]  = 32'((longint'(hi[i]) + longint'(lo[i])) / 2);
        scale[i] = 32'(q);
      end
      return ST_DONE;
    endfunction

    function void note_request(request_t rq);
      result_t ex;
      logic signed [15:0] raw[3];
      int adj;
      logic signed [31:0] outs[3];
      raw = '{rq.raw_x, rq.raw_y, rq.raw_z};
      outs = '{0, 0, 0};
      ex.status = ST_NOTREADY;
      case (rq.operation)
        OP_BEGIN: begin
          clear_extremes();
          seen = 0;
          collecting = 1;
          ex.status = ST_STARTED;
        end
        OP_END: ex.status = finish_run();
        OP_SAMPLE: begin
          if (!rq.status_one[0]) ex.status = ST_NOTREADY;
          else if (rq.status_two[3]) ex.status = ST_OVERFLOW;
          else begin
            ex.status = ST_OK;
            for (int i = 0; i < 3; i++) begin
              adj = int'(raw[i]) * int'(adjust[i] + 128);
              outs[i] = correct(adj, i);
              if (collecting) begin
                if (adj < lo[i]) lo[i] = adj;
                if (adj > hi[i]) hi[i] = adj;
              end
            end
            if (collecting) seen = 1;
          end
        end
        default: ;
      endcase
      ex.out_x = outs[0];
      ex.out_y = outs[1];
      ex.out_z = outs[2];
      ex.calibrating = collecting;
      awaited.push_back(ex);
    endfunction

    function void check_result(result_t got);
      result_t ex;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      ex = awaited.pop_front();
      if (got.status !== ex.status) begin
        $display("%0t: status expected %0d got %0d", $time, ex.status, got.status);
        errors++;
      end
      if (got.out_x !== ex.out_x) begin
        $display("%0t: out_x expected %0d got %0d", $time, ex.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== ex.out_y) begin
        $display("%0t: out_y expected %0d got %0d", $time, ex.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== ex.out_z) begin
        $display("%0t: out_z expected %0d got %0d", $time, ex.out_z, got.out_z);
        errors++;
      end
      if (got.calibrating !== ex.calibrating) begin
        $display("%0t: calibrating expected %0b got %0b", $time, ex.calibrating,
                 got.calibrating);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         hold_request;

  mic_if #(.payload_t(request_t)) req_ch ();
  mic_if #(.payload_t(result_t))  res_ch ();

  iron_scoreboard board;

  magnetometer_iron_calibration_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch.sink),
    .res       (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Receiver: toggle ready with random gaps; a hold request from the sender
  // side forces one long stall so the block backs up into its input.
  initial begin
    int hold;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        res_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        res_ch.ready = 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end else begin
        res_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Check every result the moment it is taken.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) board.check_result(res_ch.payload);
  end

  // Offer one request; return at the falling edge after it is taken.
  task automatic send(request_t rq, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    repeat (g) @(negedge clk);
    req_ch.valid   = 1'b1;
    req_ch.payload = rq;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    board.note_request(rq);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write adjustment bytes only once the block is idle.
  task automatic write_adjust(logic [1:0] idx, logic [7:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_adjust(idx, value);
  endtask

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(16'sh7fff - $urandom_range(0, 3));
      2: return 16'(16'sh8000 + $urandom_range(0, 3));
      3: return 16'($urandom_range(0, 4000) - 2000);
      default: return 16'($urandom_range(0, 40000) - 20000);
    endcase
  endfunction

  function automatic request_t make_op(op_t op);
    request_t rq;
    rq.operation  = op;
    rq.status_one = 8'($urandom);
    rq.raw_x      = 16'($urandom);
    rq.raw_y      = 16'($urandom);
    rq.raw_z      = 16'($urandom);
    rq.status_two = 8'($urandom);
    return rq;
  endfunction

  // A sample forced good when good is set; bits outside ready and overflow are random.
  function automatic request_t make_sample(bit good);
    request_t rq;
    rq = make_op(OP_SAMPLE);
    rq.raw_x = pick_raw();
    rq.raw_y = pick_raw();
    rq.raw_z = pick_raw();
    if (good) begin
      rq.status_one[0] = 1'b1;
      rq.status_two[3] = 1'b0;
    end
    return rq;
  endfunction

  function automatic request_t sample_of(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z);
    request_t rq;
    rq = make_sample(1);
    rq.raw_x = x;
    rq.raw_y = y;
    rq.raw_z = z;
    return rq;
  endfunction

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    request_t rq;
    logic [7:0] setting;
    int n;
    board = new();
    hold_request = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ADJUST_X;
    cfg_data = 8'd0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: status-only paths, not-ready ahead of overflow, unused code.
    rq = make_sample(1); rq.status_one = 8'hfe; rq.status_two = 8'hff; send(rq);
    rq = make_sample(1); rq.status_one = 8'hff; rq.status_two = 8'h08; send(rq);
    rq = make_sample(1); rq.status_one = 8'h01; rq.status_two = 8'hf7; send(rq);
    send(make_op(OP_UNUSED));
    send(make_op(OP_END));                      // no run active
    send(sample_of(16'sh7fff, 16'sh8000, 16'sd0));
    send(sample_of(16'sh8000, 16'sh7fff, -16'sd1));
    send(make_op(OP_BEGIN));
    send(make_op(OP_END));                      // run without samples
    send(make_op(OP_BEGIN));
    send(sample_of(16'sd5, 16'sd5, 16'sd5));
    send(make_op(OP_END));                      // zero span
    send(make_op(OP_BEGIN));
    send(sample_of(16'sd100, 16'sd100, 16'sd100));
    send(make_op(OP_BEGIN));                    // restart clears extremes
    send(sample_of(16'sh7fff, 16'sd2, -16'sd300));
    send(sample_of(16'sh8000, -16'sd2, 16'sd500));
    send(make_op(OP_END));
    send(sample_of(16'sh7fff, 16'sd3, 16'sd0));  // tiny span, huge scale
    send(sample_of(16'sh8000, -16'sd9, 16'sd100));

    // Extreme adjustment bytes, then back through the calibration once more.
    write_adjust(REG_ADJUST_X, 8'd0);
    write_adjust(REG_ADJUST_Y, 8'd255);
    write_adjust(REG_ADJUST_Z, 8'd255);
    send(make_op(OP_BEGIN));
    send(sample_of(16'sh7fff, 16'sh7fff, 16'sh8000));
    send(sample_of(16'sh8000, 16'sh8000, 16'sh7fff));
    send(make_op(OP_END));
    send(sample_of(16'sh7fff, 16'sh8000, 16'sd1));

    // Stall the receiver for a long stretch while requests keep coming.
    hold_request = 400;
    for (int i = 0; i < 6; i++) send(make_sample(1), 1);
    drain();

    // Random phases: each picks new adjustment bytes, then mostly well-formed
    // calibration runs with noise and broken sequences mixed in.
    for (int phase = 0; phase < 12; phase++) begin
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 3))
          0: setting = 8'd0;
          1: setting = 8'd255;
          default: setting = 8'($urandom);
        endcase
        write_adjust(a[1:0], setting);
      end
      n = 0;
      while (n < 115) begin
        case ($urandom_range(0, 9))
          0: begin
            send(make_op($urandom_range(0, 1) ? OP_UNUSED : OP_END));
            n++;
          end
          1: begin
            send(make_sample($urandom_range(0, 1)));
            n++;
          end
          default: begin
            send(make_op(OP_BEGIN));
            for (int k = $urandom_range(0, 12); k > 0; k--) begin
              send(make_sample($urandom_range(0, 7) != 0));
              n++;
            end
            if ($urandom_range(0, 5) != 0) send(make_op(OP_END));
            for (int k = $urandom_range(0, 6); k > 0; k--) begin
              send(make_sample(1));
              n++;
            end
            n += 2;
          end
        endcase
      end
    end

    drain();
    repeat (300) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
